@@ hdl/bilevel_rle_gamma_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bilevel run-length gamma encoder
// Each check is an implication sampled on the rising clock edge and held off
// while reset is low. The checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BILEVEL_RLE_GAMMA_ENCODER_ASSERT_SVH
`define BILEVEL_RLE_GAMMA_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BRGE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication.
`define BRGE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define BRGE_ASSERT(lbl, ante, cons)
`define BRGE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/brge_pkg.sv @@
// ----------------------------------------------------------------------------
// Bilevel run-length gamma encoder package
// Sizes, coding mode codes and the packed result word of the encoder.
// ----------------------------------------------------------------------------
package brge_pkg;

  localparam int COUNT_BITS = 24;
  localparam int TOTAL_BITS = 26;

  // Bit length of a run count, 0 up to COUNT_BITS.
  localparam int NB_W = $clog2(COUNT_BITS + 1);
  // Longest gamma code of one run.
  localparam int CODE_MAX = 2 * COUNT_BITS - 1;
  // Left-aligned code buffer: a partial byte plus one long and one short code.
  localparam int BUF_W = ((CODE_MAX + 15) / 8) * 8;
  localparam int SHIFT_W = $clog2(BUF_W + 1);
  localparam int FILL_W = 3;
  localparam int RES_W = $clog2(BUF_W / 8 + 1);

  localparam int IN_W = 8;
  localparam int OUT_W = ((8 + TOTAL_BITS + 1 + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - 8 - TOTAL_BITS - 1;

  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_RLE   = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  typedef struct packed {
    logic [PAD_W-1:0]      pad;
    logic                  run_overflow;
    logic [TOTAL_BITS-1:0] bit_total;
    logic [7:0]            data_byte;
  } res_t;

endpackage

@@ hdl/bilevel_rle_gamma_encoder.sv @@
// ----------------------------------------------------------------------------
// Bilevel run-length gamma encoder
// Packs one-bit pixels into bytes raw or as run-length Elias gamma codes, or
// only counts the code bits of an image.
// ----------------------------------------------------------------------------
// The encoder takes at most one pixel per clock cycle. Each pixel is coded in a
// single pass between the input register and a byte emitter; the emitter sends
// one code byte per cycle through the output register unless the output stalls,
// so a pixel whose codes complete more than one result word holds the input
// until all but the last are sent (longest when a pixel closes a long run at the
// end of an image). Raw and short-run streams run at one pixel per cycle unless
// the output stalls. The user must write the mode register through the cfg channel
// only while no image data is in flight; the block does not enforce it. Mode 3 acts as count only.
`include "bilevel_rle_gamma_encoder_assert.svh"

module bilevel_rle_gamma_encoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [brge_pkg::IN_W-1:0]    in_tdata,   // [0] pixel_bit, rest zero
  input  logic                         in_tlast,   // end_of_image
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [brge_pkg::OUT_W-1:0]   out_tdata,  // [7:0] data_byte,
                                                   // [33:8] bit_total,
                                                   // [34] run_overflow, rest zero
  output logic                         out_tuser,  // byte_present
  output logic                         out_tlast,  // final_result
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_data    // coding_mode
);

  localparam int CB  = brge_pkg::COUNT_BITS;
  localparam int TB  = brge_pkg::TOTAL_BITS;
  localparam int NBW = brge_pkg::NB_W;
  localparam int BW  = brge_pkg::BUF_W;
  localparam int SW  = brge_pkg::SHIFT_W;
  localparam int FW  = brge_pkg::FILL_W;
  localparam int RW  = brge_pkg::RES_W;

  typedef logic [CB:0] pow_t;

  localparam logic [CB-1:0] RUN_MAX   = {CB{1'b1}};
  localparam logic [TB-1:0] TOTAL_MAX = {TB{1'b1}};

  // Configuration.
  logic [1:0] mode_r;

  // Input register.
  logic in_v_r;
  logic pix_r;
  logic last_r;

  // Image state.
  logic           first_r,  first_nxt;
  logic           rval_r,   rval_nxt;
  logic [CB-1:0]  rlen_r,   rlen_nxt;
  logic [NBW-1:0] rnb_r,    rnb_nxt;
  logic [BW-1:0]  lbuf_r,   lbuf_nxt;
  logic [FW-1:0]  fill_r,   fill_nxt;
  logic [TB-1:0]  bits_r,   bits_nxt;
  logic           ovf_r,    ovf_nxt;

  // Byte emitter.
  logic [BW-1:0]  em_buf_r;
  logic [RW-1:0]  em_cnt_r;
  logic           em_final_r;
  logic           em_present_r;
  logic [TB-1:0]  em_total_r;
  logic           em_ovf_r;

  // Output register.
  logic           out_v_r;
  brge_pkg::res_t out_res_r;
  logic           out_present_r;
  logic           out_last_r;

  // Coding logic.
  logic [CB-1:0]  code1, code2;
  logic [SW-1:0]  len1, len2;
  logic [CB-1:0]  rlen_inc;
  logic           cnt_only;
  logic [SW-1:0]  s1, s2, fillc;
  logic [BW-1:0]  agg;
  logic [RW-1:0]  nbytes, nres;
  logic           flush;
  logic           empty_final;
  logic [TB:0]    bits_sum;

  logic           em_move;
  logic           em_free;
  logic           proc_go;
  brge_pkg::res_t em_res;
  logic           em_last_word;

  assign cfg_ready = 1'b1;
  assign cnt_only  = mode_r[1];
  assign rlen_inc  = rlen_r + CB'(1);

  // Run tracking and the codes this pixel produces. A gamma code of n is n
  // itself in a field of 2*len(n)-1 bits: the leading zeros come for free.
  always_comb begin
    code1     = '0;
    len1      = '0;
    code2     = '0;
    len2      = '0;
    first_nxt = first_r;
    rval_nxt  = rval_r;
    rlen_nxt  = rlen_r;
    rnb_nxt   = rnb_r;
    ovf_nxt   = ovf_r;
    if (mode_r == brge_pkg::MODE_RAW) begin
      code1     = CB'(pix_r);
      len1      = SW'(1);
      first_nxt = 1'b0;
      rlen_nxt  = '0;
      rnb_nxt   = '0;
    end else begin
      if (first_r) begin
        code1     = CB'(pix_r);
        len1      = SW'(1);
        first_nxt = 1'b0;
        rval_nxt  = pix_r;
        rlen_nxt  = CB'(1);
        rnb_nxt   = NBW'(1);
      end else if (rlen_r == '0) begin
        rval_nxt = pix_r;
        rlen_nxt = CB'(1);
        rnb_nxt  = NBW'(1);
      end else if (pix_r == rval_r) begin
        if (rlen_r != RUN_MAX) begin
          rlen_nxt = rlen_inc;
          // The bit length grows when the count reaches the next power of two.
          if ({1'b0, rlen_inc} == (pow_t'(1) << rnb_r)) begin
            rnb_nxt = rnb_r + NBW'(1);
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end else begin
        code1    = rlen_r;
        len1     = (SW'(rnb_r) << 1) - SW'(1);
        rval_nxt = pix_r;
        rlen_nxt = CB'(1);
        rnb_nxt  = NBW'(1);
      end
      if (last_r) begin
        code2    = rlen_nxt;
        len2     = (SW'(rnb_nxt) << 1) - SW'(1);
        rlen_nxt = '0;
        rnb_nxt  = '0;
      end
    end
  end

  // Append the codes below the bits already held in the left-aligned buffer.
  always_comb begin
    s1       = SW'(BW) - SW'(fill_r) - len1;
    s2       = s1 - len2;
    bits_sum = {1'b0, bits_r} + (TB + 1)'(len1) + (TB + 1)'(len2);
    bits_nxt = bits_sum[TB] ? TOTAL_MAX : bits_sum[TB-1:0];
    if (cnt_only) begin
      agg   = lbuf_r;
      fillc = SW'(fill_r);
    end else begin
      agg   = lbuf_r | (BW'(code1) << s1) | (BW'(code2) << s2);
      fillc = SW'(fill_r) + len1 + len2;
    end
    nbytes      = cnt_only ? '0 : RW'(fillc[SW-1:3]);
    flush       = last_r && !cnt_only && (fillc[2:0] != '0);
    empty_final = last_r && (nbytes == '0) && !flush;
    nres        = empty_final ? RW'(1) : nbytes + RW'(flush);
    lbuf_nxt    = cnt_only ? lbuf_r : agg << (SW'(nbytes) << 3);
    fill_nxt    = cnt_only ? fill_r : fillc[FW-1:0];
  end

  // Handshake chain: the emitter hands a word to the output register when that
  // register is empty or being drained, and takes a new pixel's words when it
  // is about to run dry.
  assign em_move   = (em_cnt_r != '0) && (!out_v_r || out_tready);
  assign em_free   = (em_cnt_r == '0) || ((em_cnt_r == RW'(1)) && em_move);
  assign proc_go   = in_v_r && em_free;
  assign in_tready = !in_v_r || proc_go;

  assign em_last_word = em_final_r && (em_cnt_r == RW'(1));

  always_comb begin
    em_res              = '0;
    em_res.data_byte    = em_present_r ? em_buf_r[BW-1 -: 8] : 8'd0;
    em_res.bit_total    = em_last_word ? em_total_r : '0;
    em_res.run_overflow = em_ovf_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= brge_pkg::MODE_RLE;
      in_v_r   <= 1'b0;
      first_r  <= 1'b1;
      rval_r   <= 1'b0;
      rlen_r   <= '0;
      rnb_r    <= '0;
      lbuf_r   <= '0;
      fill_r   <= '0;
      bits_r   <= '0;
      ovf_r    <= 1'b0;
      em_cnt_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (proc_go) begin
        in_v_r <= 1'b0;
      end
      if (em_move && !proc_go) begin
        em_cnt_r <= em_cnt_r - RW'(1);
      end
      if (proc_go) begin
        em_cnt_r <= nres;
        if (last_r) begin
          first_r <= 1'b1;
          rval_r  <= 1'b0;
          rlen_r  <= '0;
          rnb_r   <= '0;
          lbuf_r  <= '0;
          fill_r  <= '0;
          bits_r  <= '0;
          ovf_r   <= 1'b0;
        end else begin
          first_r <= first_nxt;
          rval_r  <= rval_nxt;
          rlen_r  <= rlen_nxt;
          rnb_r   <= rnb_nxt;
          lbuf_r  <= lbuf_nxt;
          fill_r  <= fill_nxt;
          bits_r  <= bits_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
      if (em_move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pix_r  <= in_tdata[0];
      last_r <= in_tlast;
    end
    if (em_move && !proc_go) begin
      em_buf_r <= em_buf_r << 8;
    end
    if (proc_go) begin
      em_buf_r     <= agg;
      em_final_r   <= last_r;
      em_present_r <= !empty_final;
      em_total_r   <= bits_nxt;
      em_ovf_r     <= ovf_nxt;
    end
    if (em_move) begin
      out_res_r     <= em_res;
      out_present_r <= em_present_r;
      out_last_r    <= em_last_word;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_present_r;
  assign out_tlast  = out_last_r;

  // A word without a byte is only ever the closing word of an image.
  `BRGE_ASSERT(a_empty_is_final, out_tvalid && !out_tuser, out_tlast)
  // The bit total is only reported on the closing word.
  `BRGE_ASSERT(a_total_on_final, out_tvalid && !out_tlast, out_tdata[33:8] == '0)
  // The tracked bit length matches the run count.
  `BRGE_ASSERT(a_run_bits, rlen_r != '0,
               (rnb_r != '0) && ((rlen_r >> (rnb_r - NBW'(1))) == CB'(1)))
  // Closing an image leaves the coder ready for a fresh one.
  `BRGE_ASSERT_NXT(a_image_cleared, proc_go && last_r,
                   first_r && (fill_r == '0) && (bits_r == '0) && !ovf_r)

endmodule
